>>> rtl/onse_pkg.sv
package onse_pkg;

  // default for the largest vector length
  localparam int MAX_VECTOR_LENGTH_DEF = 4096;

  // register and field widths
  localparam int CFG_W      = 13;
  localparam int PH_W       = 12;
  localparam int POWER_W    = 32;
  localparam int QUOT_W     = 32;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // q16 fraction plus one rounding bit
  localparam int DIV_FRAC_SHIFT = 17;

  // front to back queue
  localparam int QUEUE_DEPTH = 2;

  // register map, selected by paddr[2]
  localparam logic REG_VECTOR_LENGTH = 1'b0;
  localparam logic REG_PILOT_SPACING = 1'b1;

  localparam logic [CFG_W-1:0] VECTOR_LENGTH_RESET = 13'd64;
  localparam logic [CFG_W-1:0] PILOT_SPACING_RESET = 13'd4;

  localparam int LENGTH_MIN  = 2;
  localparam int SPACING_MIN = 2;
  localparam int SPACING_MAX = 4096;

  localparam logic [31:0] SNR_POS_SAT = 32'h7FFF_FFFF;
  localparam logic [31:0] SNR_NEG_SAT = 32'h8000_0000;
  localparam logic [31:0] NOISE_SAT   = 32'hFFFF_FFFF;

  // divider status seen by the back end
  typedef struct packed {
    logic done;
    logic ovf;
  } div_status_t;

endpackage

>>> rtl/onse_sample_if.sv
interface onse_sample_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample_re;
  logic signed [15:0] sample_im;

  modport source (output valid, output sample_re, output sample_im, input ready);
  modport sink (input valid, input sample_re, input sample_im, output ready);
endinterface

>>> rtl/onse_result_if.sv
interface onse_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] snr_estimate;
  logic        [31:0] noise_power;
  logic               null_sum_zero;

  modport source (output valid, output snr_estimate, output noise_power,
                  output null_sum_zero, input ready);
  modport sink (input valid, input snr_estimate, input noise_power,
                input null_sum_zero, output ready);
endinterface

>>> rtl/ofdm_null_subcarrier_snr_estimator_top.sv
// result path: the last sample passes front stages 1 and 2, the queue, three multiply
//   steps, a difference, two bit-serial divisions; a zero null sum skips these
// throughput: one sample per cycle; a last sample stalls until the queue has room,
//   the shared divider paces the back end, and a 2-entry queue absorbs short vectors
// reset: synchronous, active high; clears counters, sums, queue, sequencer and
//   output valid; vector_length returns to 64 and pilot_spacing to 4
module ofdm_null_subcarrier_snr_estimator_top
  import onse_pkg::*;
#(
  parameter int MAX_VECTOR_LENGTH = MAX_VECTOR_LENGTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  onse_sample_if.sink           sample,
  onse_result_if.source         result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  // sums must hold MAX_VECTOR_LENGTH powers of up to 2^31
  localparam int SUM_W   = 32 + $clog2(MAX_VECTOR_LENGTH);
  // queue entry: length, spacing, null sum, loaded sum
  localparam int ENTRY_W = 2*SUM_W + 2*CFG_W;
  localparam int QCNT_W  = $clog2(QUEUE_DEPTH+1);

  logic [CFG_W-1:0]   vector_length;
  logic [CFG_W-1:0]   pilot_spacing;
  logic               cfg_write;

  logic               q_push;
  logic [ENTRY_W-1:0] q_push_data;
  logic               q_pop;
  logic [ENTRY_W-1:0] q_head;
  logic [QCNT_W-1:0]  q_count;

  // configuration registers, one per word; paddr[2] picks the register
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      vector_length <= VECTOR_LENGTH_RESET;
      pilot_spacing <= PILOT_SPACING_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_VECTOR_LENGTH: vector_length <= pwdata[CFG_W-1:0];
        REG_PILOT_SPACING: pilot_spacing <= pwdata[CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_PILOT_SPACING: prdata = APB_DATA_W'(pilot_spacing);
      default:           prdata = APB_DATA_W'(vector_length);
    endcase
  end

  // front: per-sample power, position tracking and accumulation
  onse_front #(
    .MAX_VECTOR_LENGTH (MAX_VECTOR_LENGTH),
    .SUM_W             (SUM_W),
    .ENTRY_W           (ENTRY_W)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .vector_length (vector_length),
    .pilot_spacing (pilot_spacing),
    .sample        (sample),
    .queue_count   (q_count),
    .push          (q_push),
    .push_data     (q_push_data)
  );

  // finished vectors wait here while the back end divides
  onse_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .head      (q_head),
    .count     (q_count)
  );

  // back: products, snr and noise divisions, output register with transfer handshake
  onse_back #(
    .MAX_VECTOR_LENGTH (MAX_VECTOR_LENGTH),
    .SUM_W             (SUM_W),
    .ENTRY_W           (ENTRY_W)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (q_head),
    .queue_count (q_count),
    .pop         (q_pop),
    .result      (result)
  );

endmodule

>>> rtl/onse_fifo.sv
module onse_fifo
  import onse_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           push_data,
  input  logic                       pop,
  output logic [WIDTH-1:0]           head,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(DEPTH-1)) return '0;
    return p + 1'b1;
  endfunction

  assign head = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wrap_inc(wptr);
      if (pop) rptr <= wrap_inc(rptr);
      if (push && !pop) count <= count + CNT_W'(1);
      else if (pop && !push) count <= count - CNT_W'(1);
    end
  end

endmodule

>>> rtl/onse_front.sv
module onse_front
  import onse_pkg::*;
#(
  parameter int MAX_VECTOR_LENGTH = MAX_VECTOR_LENGTH_DEF,
  parameter int SUM_W = 32 + $clog2(MAX_VECTOR_LENGTH),
  parameter int ENTRY_W = 2*SUM_W + 2*CFG_W
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [CFG_W-1:0]                 vector_length,
  input  logic [CFG_W-1:0]                 pilot_spacing,
  onse_sample_if.sink                      sample,
  input  logic [$clog2(QUEUE_DEPTH+1)-1:0] queue_count,
  output logic                             push,
  output logic [ENTRY_W-1:0]               push_data
);

  localparam int PC_W    = $clog2(MAX_VECTOR_LENGTH);
  localparam int CMP_W   = (PC_W + 1 > CFG_W) ? PC_W + 1 : CFG_W;
  localparam int LEN_CAP = (MAX_VECTOR_LENGTH > 8191) ? 8191 : MAX_VECTOR_LENGTH;
  localparam int QCNT_W  = $clog2(QUEUE_DEPTH+1);

  logic [PC_W-1:0]    position_count;
  logic [PH_W-1:0]    spacing_phase;
  logic [SUM_W-1:0]   loaded_power_sum;
  logic [SUM_W-1:0]   null_power_sum;

  logic [CFG_W-1:0]   eff_len;
  logic [CFG_W-1:0]   eff_s;
  logic               is_last;
  logic               is_loaded;
  logic               room_for_last;
  logic               accept;
  logic signed [31:0] re_sq;
  logic signed [31:0] im_sq;
  logic [POWER_W-1:0] power;

  // stage 1: power and position class
  logic               p1_valid;
  logic [POWER_W-1:0] p1_power;
  logic               p1_loaded;
  logic               p1_last;
  logic [CFG_W-1:0]   p1_len;
  logic [CFG_W-1:0]   p1_s;

  logic [SUM_W-1:0]   loaded_new;
  logic [SUM_W-1:0]   null_new;

  always_comb begin
    eff_len = vector_length;
    if (vector_length < CFG_W'(LENGTH_MIN)) eff_len = CFG_W'(LENGTH_MIN);
    else if (32'(vector_length) > 32'(LEN_CAP)) eff_len = CFG_W'(LEN_CAP);
    eff_s = pilot_spacing;
    if (pilot_spacing < CFG_W'(SPACING_MIN)) eff_s = CFG_W'(SPACING_MIN);
    else if (pilot_spacing > CFG_W'(SPACING_MAX)) eff_s = CFG_W'(SPACING_MAX);
  end

  assign is_last   = !((CMP_W'(position_count) + CMP_W'(1)) < CMP_W'(eff_len));
  assign is_loaded = (spacing_phase == '0);

  // a last sample is taken only if its queue entry is sure to fit
  assign room_for_last = (QCNT_W'(queue_count) + QCNT_W'(p1_valid && p1_last))
                         < QCNT_W'(QUEUE_DEPTH);
  assign sample.ready  = !is_last || room_for_last;
  assign accept        = sample.valid && sample.ready;

  assign re_sq = sample.sample_re * sample.sample_re;
  assign im_sq = sample.sample_im * sample.sample_im;
  assign power = $unsigned(re_sq) + $unsigned(im_sq);

  always_ff @(posedge clk) begin
    if (rst) begin
      position_count <= '0;
      spacing_phase  <= '0;
      p1_valid       <= 1'b0;
    end else begin
      p1_valid <= accept;
      if (accept) begin
        if (is_last) begin
          position_count <= '0;
          spacing_phase  <= '0;
        end else begin
          position_count <= position_count + 1'b1;
          if ((CFG_W'(spacing_phase) + CFG_W'(1)) >= eff_s) spacing_phase <= '0;
          else spacing_phase <= spacing_phase + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1_power  <= power;
      p1_loaded <= is_loaded;
      p1_last   <= is_last;
      p1_len    <= eff_len;
      p1_s      <= eff_s;
    end
  end

  // stage 2: accumulate, hand finished vectors to the queue
  assign loaded_new = loaded_power_sum + (p1_loaded ? SUM_W'(p1_power) : '0);
  assign null_new   = null_power_sum + (p1_loaded ? '0 : SUM_W'(p1_power));
  assign push       = p1_valid && p1_last;
  assign push_data  = {p1_len, p1_s, null_new, loaded_new};

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded_power_sum <= '0;
      null_power_sum   <= '0;
    end else if (p1_valid) begin
      if (p1_last) begin
        loaded_power_sum <= '0;
        null_power_sum   <= '0;
      end else begin
        loaded_power_sum <= loaded_new;
        null_power_sum   <= null_new;
      end
    end
  end

endmodule

>>> rtl/onse_div.sv
module onse_div
  import onse_pkg::*;
#(
  parameter int DW = 57,
  parameter int XW = DW + DIV_FRAC_SHIFT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [XW-1:0]     dividend,
  input  logic [DW-1:0]     divisor,
  output div_status_t       status,
  output logic [QUOT_W-1:0] quot
);

  localparam int CNT_W = $clog2(QUOT_W);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [DW-1:0]     rem;
  logic [DW-1:0]     dvsr;
  logic [DW-1:0]     hi;
  logic              hi_ovf;
  logic [DW:0]       trial;
  logic              ge;
  logic [DW:0]       diff;

  // quotient fits in QUOT_W bits only if the upper dividend part is below divisor
  assign hi     = DW'(dividend[XW-1:QUOT_W]);
  assign hi_ovf = (hi >= divisor);

  assign trial = {rem, quot[QUOT_W-1]};
  assign ge    = (trial >= {1'b0, dvsr});
  assign diff  = trial - {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      status.done <= 1'b0;
      status.ovf  <= 1'b0;
      cnt         <= '0;
    end else begin
      status.done <= 1'b0;
      if (start) begin
        busy        <= !hi_ovf;
        status.done <= hi_ovf;
        status.ovf  <= hi_ovf;
        cnt         <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(QUOT_W-1)) begin
          busy        <= 1'b0;
          status.done <= 1'b1;
        end
      end
    end
  end

  // one restoring step a cycle, quotient bits shift in from the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= hi;
      dvsr <= divisor;
      quot <= dividend[QUOT_W-1:0];
    end else if (busy) begin
      rem  <= ge ? diff[DW-1:0] : trial[DW-1:0];
      quot <= {quot[QUOT_W-2:0], ge};
    end
  end

endmodule

>>> rtl/onse_back.sv
module onse_back
  import onse_pkg::*;
#(
  parameter int MAX_VECTOR_LENGTH = MAX_VECTOR_LENGTH_DEF,
  parameter int SUM_W = 32 + $clog2(MAX_VECTOR_LENGTH),
  parameter int ENTRY_W = 2*SUM_W + 2*CFG_W
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [ENTRY_W-1:0]               head,
  input  logic [$clog2(QUEUE_DEPTH+1)-1:0] queue_count,
  output logic                             pop,
  onse_result_if.source                    result
);

  localparam int PROD_W = SUM_W + CFG_W;
  localparam int XW     = PROD_W + DIV_FRAC_SHIFT;

  typedef enum logic [9:0] {
    S_IDLE       = 10'b00_0000_0001,
    S_MUL_T      = 10'b00_0000_0010,
    S_MUL_N      = 10'b00_0000_0100,
    S_MUL_D      = 10'b00_0000_1000,
    S_DIFF       = 10'b00_0001_0000,
    S_DIV_SNR    = 10'b00_0010_0000,
    S_WAIT_SNR   = 10'b00_0100_0000,
    S_DIV_NOISE  = 10'b00_1000_0000,
    S_WAIT_NOISE = 10'b01_0000_0000,
    S_OUT        = 10'b10_0000_0000
  } back_state_t;

  back_state_t state;
  back_state_t state_next;

  logic [SUM_W-1:0]  l_sum;
  logic [SUM_W-1:0]  n_sum;
  logic [CFG_W-1:0]  sp;
  logic [CFG_W-1:0]  len;
  logic [PROD_W-1:0] t_prod;
  logic [PROD_W-1:0] nd_prod;
  logic [PROD_W-1:0] den_prod;
  logic [PROD_W-1:0] diff;
  logic              neg;
  logic [31:0]       snr;
  logic [31:0]       noise;
  logic              flag;

  logic [SUM_W-1:0]  head_l;
  logic [SUM_W-1:0]  head_n;
  logic [CFG_W-1:0]  head_s;
  logic [CFG_W-1:0]  head_len;

  logic [CFG_W-1:0]  mul_a;
  logic [SUM_W-1:0]  mul_b;
  logic [PROD_W-1:0] prod;
  logic [PROD_W:0]   noise_num;

  logic              div_start;
  logic [XW-1:0]     div_dividend;
  logic [PROD_W-1:0] div_divisor;
  div_status_t       div_status;
  logic [QUOT_W-1:0] div_quot;

  logic [QUOT_W:0]   rounded;
  logic [31:0]       mag;
  logic [31:0]       snr_calc;
  logic              out_load;

  assign {head_len, head_s, head_n, head_l} = head;
  assign pop = (state == S_IDLE) && (queue_count != '0);

  // one shared multiplier, three products in turn
  always_comb begin
    mul_a = sp - CFG_W'(1);
    mul_b = l_sum;
    unique case (state)
      S_MUL_N: begin
        mul_a = sp;
        mul_b = n_sum;
      end
      S_MUL_D: begin
        mul_b = SUM_W'(len);
      end
      default: begin
      end
    endcase
  end
  assign prod = mul_a * mul_b;

  assign noise_num = {1'b0, nd_prod} + {1'b0, den_prod >> 1};

  always_comb begin
    div_start    = 1'b0;
    div_dividend = {diff, {DIV_FRAC_SHIFT{1'b0}}};
    div_divisor  = nd_prod;
    unique case (state)
      S_DIV_SNR: begin
        div_start = 1'b1;
      end
      S_DIV_NOISE: begin
        div_start    = 1'b1;
        div_dividend = XW'(noise_num);
        div_divisor  = den_prod;
      end
      default: begin
      end
    endcase
  end

  onse_div #(
    .DW (PROD_W),
    .XW (XW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .status   (div_status),
    .quot     (div_quot)
  );

  // round the q17 quotient to q16, half away from zero, then saturate per sign
  assign rounded = {1'b0, div_quot} + (QUOT_W+1)'(1);
  assign mag     = rounded[QUOT_W:1];

  always_comb begin
    if (!neg) begin
      snr_calc = (div_status.ovf || mag[31]) ? SNR_POS_SAT : mag;
    end else begin
      snr_calc = div_status.ovf ? SNR_NEG_SAT : (32'd0 - mag);
    end
  end

  assign out_load = (state == S_OUT) && (!result.valid || result.ready);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (queue_count != '0) begin
          state_next = (head_n == '0) ? S_OUT : S_MUL_T;
        end
      end
      S_MUL_T:      state_next = S_MUL_N;
      S_MUL_N:      state_next = S_MUL_D;
      S_MUL_D:      state_next = S_DIFF;
      S_DIFF:       state_next = S_DIV_SNR;
      S_DIV_SNR:    state_next = S_WAIT_SNR;
      S_WAIT_SNR:   if (div_status.done) state_next = S_DIV_NOISE;
      S_DIV_NOISE:  state_next = S_WAIT_NOISE;
      S_WAIT_NOISE: if (div_status.done) state_next = S_OUT;
      S_OUT:        if (out_load) state_next = S_IDLE;
      default:      state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        l_sum <= head_l;
        n_sum <= head_n;
        sp    <= head_s;
        len   <= head_len;
        flag  <= (head_n == '0);
        snr   <= SNR_POS_SAT;
        noise <= '0;
      end
      S_MUL_T: t_prod   <= prod;
      S_MUL_N: nd_prod  <= prod;
      S_MUL_D: den_prod <= prod;
      S_DIFF: begin
        if (t_prod >= PROD_W'(n_sum)) begin
          diff <= t_prod - PROD_W'(n_sum);
          neg  <= 1'b0;
        end else begin
          diff <= PROD_W'(n_sum) - t_prod;
          neg  <= 1'b1;
        end
      end
      S_WAIT_SNR: begin
        if (div_status.done) snr <= snr_calc;
      end
      S_WAIT_NOISE: begin
        if (div_status.done) noise <= div_status.ovf ? NOISE_SAT : div_quot;
      end
      default: begin
      end
    endcase
  end

  // output register, freed by a transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (out_load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.snr_estimate  <= snr;
      result.noise_power   <= noise;
      result.null_sum_zero <= flag;
    end
  end

endmodule

>>> sim/tb_ofdm_null_subcarrier_snr_estimator_top.sv
module tb_ofdm_null_subcarrier_snr_estimator_top
  import onse_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // cycles with no transfer of any kind before the run is declared hung
  localparam int unsigned STALL_LIMIT = 4000;
  // settle time after the last result, covers the back end divider
  localparam int unsigned SETTLE_CYCLES = 100;

  typedef struct packed {
    logic signed [31:0] snr_estimate;
    logic        [31:0] noise_power;
    logic               null_sum_zero;
  } snr_report_t;

  // how sample content is drawn; loaded vs null comes from the spacing phase
  typedef enum int unsigned {
    MIX_UNIFORM,
    MIX_PILOT_TONE,
    MIX_SILENT_NULLS,
    MIX_RAIL
  } sample_mix_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  onse_sample_if sample_ch ();
  onse_result_if result_ch ();

  ofdm_null_subcarrier_snr_estimator_top dut (
    .clk     (clk),
    .rst     (rst),
    .sample  (sample_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // estimator shadow: register copies and the running vector state
  logic [CFG_W-1:0] length_reg   = VECTOR_LENGTH_RESET;
  logic [CFG_W-1:0] spacing_reg  = PILOT_SPACING_RESET;
  int unsigned      position_idx = 0;
  int unsigned      phase_idx    = 0;
  bit [63:0]        loaded_sum   = '0;
  bit [63:0]        null_sum     = '0;

  snr_report_t expected_reports[$];
  int unsigned failures = 0;

  // idle control for both channels
  bit          sender_gaps_on   = 1'b1;
  bit          result_stalls_on = 1'b1;
  int unsigned hold_request     = 0;
  int unsigned ready_hold       = 0;
  int unsigned quiet_cycles     = 0;

  logic signed [15:0] rail_values [5] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001};

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  function automatic int unsigned active_length();
    if (length_reg < LENGTH_MIN) return LENGTH_MIN;
    if (length_reg > MAX_VECTOR_LENGTH_DEF) return MAX_VECTOR_LENGTH_DEF;
    return length_reg;
  endfunction

  function automatic int unsigned active_spacing();
    if (spacing_reg < SPACING_MIN) return SPACING_MIN;
    if (spacing_reg > SPACING_MAX) return SPACING_MAX;
    return spacing_reg;
  endfunction

  // samples still needed to close the current vector
  function automatic int unsigned vector_remaining();
    if (position_idx + 1 >= active_length()) return 1;
    return active_length() - position_idx;
  endfunction

  // rounded num/den with 16 fraction bits; 0x8000_0000 flags an overflow
  function automatic bit [63:0] rounded_q16_ratio(input bit [63:0] num, input bit [63:0] den);
    bit [63:0] whole;
    bit [63:0] rem;
    bit [63:0] acc;
    whole = num / den;
    rem   = num % den;
    if (whole >= 64'd32768) return 64'h8000_0000;
    acc = whole;
    for (int k = 0; k < DIV_FRAC_SHIFT; k++) begin
      rem = rem << 1;
      acc = acc << 1;
      if (rem >= den) begin
        rem    = rem - den;
        acc[0] = 1'b1;
      end
    end
    return (acc + 64'd1) >> 1;
  endfunction

  // folds one accepted sample into the sums; returns 1 when a vector closes
  function automatic bit accumulate_sample(input logic signed [15:0] re,
                                           input logic signed [15:0] im,
                                           output snr_report_t rep);
    bit [63:0]   power;
    bit [63:0]   t;
    bit [63:0]   nd;
    bit [63:0]   den;
    bit [63:0]   mag;
    bit [63:0]   noise;
    int unsigned len;
    int unsigned s;
    len   = active_length();
    s     = active_spacing();
    power = 64'(longint'(re) * longint'(re) + longint'(im) * longint'(im));
    rep   = '0;
    if (phase_idx == 0) loaded_sum += power;
    else null_sum += power;
    phase_idx = (phase_idx + 1 >= s) ? 0 : phase_idx + 1;
    if (position_idx + 1 < len) begin
      position_idx++;
      return 1'b0;
    end

    if (null_sum == 0) begin
      // silent null positions: flag, snr pinned high, no noise
      rep.null_sum_zero = 1'b1;
      rep.snr_estimate  = SNR_POS_SAT;
      rep.noise_power   = '0;
    end else begin
      t  = 64'(s - 1) * loaded_sum;
      nd = 64'(s) * null_sum;
      if (t >= null_sum) begin
        mag = rounded_q16_ratio(t - null_sum, nd);
        rep.snr_estimate = (mag > 64'h7FFF_FFFF) ? SNR_POS_SAT : mag[31:0];
      end else begin
        mag = rounded_q16_ratio(null_sum - t, nd);
        if (mag > 64'h8000_0000) mag = 64'h8000_0000;
        rep.snr_estimate = 32'd0 - mag[31:0];
      end
      den   = 64'(s - 1) * 64'(len);
      noise = (nd + den / 2) / den;
      rep.noise_power = (noise > 64'hFFFF_FFFF) ? NOISE_SAT : noise[31:0];
    end
    position_idx = 0;
    phase_idx    = 0;
    loaded_sum   = '0;
    null_sum     = '0;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // mostly short gaps, now and then a long one
  function automatic int unsigned idle_cycles();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic sample_mix_t pick_mix();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return MIX_PILOT_TONE;
    if (r < 65) return MIX_UNIFORM;
    if (r < 80) return MIX_SILENT_NULLS;
    return MIX_RAIL;
  endfunction

  function automatic void pick_sample(input sample_mix_t mix,
                                      output logic signed [15:0] re, im);
    int amp;
    int mag;
    bit loaded;
    loaded = (phase_idx == 0);
    case (mix)
      MIX_PILOT_TONE: begin
        if (loaded) begin
          // strong pilot on a loaded position
          mag = $urandom_range(4096, 32767);
          re  = 16'($urandom_range(0, 1) ? -mag : mag);
          mag = $urandom_range(0, 32767);
          im  = 16'($urandom_range(0, 1) ? -mag : mag);
        end else begin
          // weak noise of random scale on a null position
          amp = 1 << $urandom_range(0, 12);
          re  = 16'(int'($urandom_range(0, 2 * amp)) - amp);
          im  = 16'(int'($urandom_range(0, 2 * amp)) - amp);
        end
      end
      MIX_SILENT_NULLS: begin
        re = loaded ? 16'($urandom) : 16'h0000;
        im = loaded ? 16'($urandom) : 16'h0000;
      end
      MIX_RAIL: begin
        re = rail_values[$urandom_range(0, 4)];
        im = rail_values[$urandom_range(0, 4)];
      end
      default: begin
        re = 16'($urandom);
        im = 16'($urandom);
      end
    endcase
  endfunction

  // one sample transfer, then the shadow absorbs it
  task automatic send_sample(input logic signed [15:0] re, input logic signed [15:0] im);
    int unsigned gap;
    snr_report_t rep;
    gap = sender_gaps_on ? idle_cycles() : 0;
    @(negedge clk);
    if (gap != 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample_ch.valid     <= 1'b1;
    sample_ch.sample_re <= re;
    sample_ch.sample_im <= im;
    do @(posedge clk); while (!sample_ch.ready);
    if (accumulate_sample(re, im, rep)) expected_reports.push_back(rep);
  endtask

  task automatic send_samples(input int unsigned count, input sample_mix_t mix);
    logic signed [15:0] re;
    logic signed [15:0] im;
    repeat (count) begin
      pick_sample(mix, re, im);
      send_sample(re, im);
    end
  endtask

  // sender goes quiet until every predicted report has come back
  task automatic wait_results_drained();
    @(negedge clk);
    sample_ch.valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
  endtask

  function automatic void report_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      failures++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // register port
  // ---------------------------------------------------------------------------

  task automatic apb_access(input logic wr, input logic sel,
                            input logic [APB_DATA_W-1:0] wdata,
                            output logic [APB_DATA_W-1:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {sel, 2'b00};
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    if (wr) begin
      if (sel == REG_VECTOR_LENGTH) length_reg = wdata[CFG_W-1:0];
      else spacing_reg = wdata[CFG_W-1:0];
    end
  endtask

  task automatic verify_registers();
    logic [APB_DATA_W-1:0] rd;
    apb_access(1'b0, REG_VECTOR_LENGTH, '0, rd);
    report_field("vector_length", APB_DATA_W'(length_reg), rd);
    apb_access(1'b0, REG_PILOT_SPACING, '0, rd);
    report_field("pilot_spacing", APB_DATA_W'(spacing_reg), rd);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // new format only once the back end has gone quiet
  task automatic program_vector_format(input logic [CFG_W-1:0] len,
                                       input logic [CFG_W-1:0] sp);
    logic [APB_DATA_W-1:0] rd;
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    apb_access(1'b1, REG_VECTOR_LENGTH, APB_DATA_W'(len), rd);
    apb_access(1'b1, REG_PILOT_SPACING, APB_DATA_W'(sp), rd);
    verify_registers();
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset format: 64 samples, spacing 4, read back the defaults
  task automatic test_reset_format();
    verify_registers();
    send_samples(active_length(), MIX_PILOT_TONE);
  endtask

  task automatic test_short_vector_corners();
    // both registers below range, clamp to the shortest vector
    program_vector_format(13'd0, 13'd1);
    // full-scale pilot against a slightly larger null: negative estimate
    send_sample(16'sh7FFF, 16'sh7FFF);
    send_sample(16'sh8000, 16'sh8000);
    // silent null position: flag raised
    send_sample(16'sh8000, 16'sh8000);
    send_sample(16'sh0000, 16'sh0000);
    program_vector_format(13'd1, 13'd2);
    // nothing at all in the vector
    send_sample(16'sh0000, 16'sh0000);
    send_sample(16'sh0000, 16'sh0000);
    // spacing above range and above the length: only position 0 loaded,
    // tiny null power pushes the estimate into positive saturation
    program_vector_format(13'd3, 13'd8191);
    send_sample(16'sh7FFF, 16'sh0000);
    send_sample(16'sh0000, 16'sh0001);
    send_sample(16'sh0001, 16'sh0000);
    // format change inside a vector: length drops below the position reached,
    // so the next sample closes the vector under the new spacing
    program_vector_format(13'd8, 13'd4);
    send_samples(5, MIX_UNIFORM);
    program_vector_format(13'd3, 13'd3);
    send_sample(16'sh1234, 16'shEDCB);
  endtask

  task automatic test_random_vectors();
    int unsigned r;
    int unsigned len;
    int unsigned sp;
    int unsigned sent;
    int unsigned n;
    repeat (8) begin
      r   = $urandom_range(0, 99);
      len = (r < 70) ? $urandom_range(2, 16) :
            (r < 90) ? $urandom_range(17, 48) : $urandom_range(0, 1);
      r   = $urandom_range(0, 99);
      sp  = (r < 60) ? $urandom_range(2, 8) :
            (r < 80) ? $urandom_range(len, len + 3) :
            (r < 90) ? $urandom_range(0, 1) : $urandom_range(9, 40);
      // some phases run with no idling on either side
      sender_gaps_on   = ($urandom_range(0, 3) != 0);
      result_stalls_on = ($urandom_range(0, 3) != 0);
      program_vector_format(CFG_W'(len), CFG_W'(sp));
      sent = 0;
      while (sent < 60) begin
        n = vector_remaining();
        send_samples(n, pick_mix());
        sent += n;
      end
      // cut a vector short so the next format lands mid-vector
      if ($urandom_range(0, 1)) send_samples($urandom_range(1, active_length() - 1), pick_mix());
    end
    sender_gaps_on   = 1'b1;
    result_stalls_on = 1'b1;
  endtask

  // receiver holds off while short vectors keep coming: queue fills, input stalls
  task automatic test_result_backpressure();
    program_vector_format(13'd2, 13'd3);
    sender_gaps_on = 1'b0;
    hold_request   = 400;
    send_samples(48, MIX_UNIFORM);
    wait_results_drained();
    sender_gaps_on = 1'b1;
    send_samples(16, MIX_PILOT_TONE);
  endtask

  // long vector with rail samples, spacing all ones clamps past the length
  task automatic test_long_vector();
    program_vector_format(13'd256, 13'd8191);
    sender_gaps_on = 1'b0;
    send_samples(active_length(), MIX_RAIL);
    sender_gaps_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  // receiver idling: random gaps, or a long hold-off when a test asks for one
  always @(negedge clk) begin
    if (hold_request != 0) begin
      ready_hold   = hold_request;
      hold_request = 0;
    end else if (ready_hold == 0 && result_stalls_on && $urandom_range(0, 3) == 0) begin
      ready_hold = idle_cycles();
    end
    if (ready_hold != 0) begin
      result_ch.ready <= 1'b0;
      ready_hold--;
    end else begin
      result_ch.ready <= 1'b1;
    end
  end

  // every result transfer is matched against the oldest prediction
  always @(posedge clk) begin : check_results
    snr_report_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (expected_reports.size() == 0) begin
        $display("%0t: result with none expected, actual snr %h noise %h flag %b", $time,
                 result_ch.snr_estimate, result_ch.noise_power, result_ch.null_sum_zero);
        failures++;
      end else begin
        want = expected_reports.pop_front();
        report_field("snr_estimate", want.snr_estimate, result_ch.snr_estimate);
        report_field("noise_power", want.noise_power, result_ch.noise_power);
        report_field("null_sum_zero", 32'(want.null_sum_zero), 32'(result_ch.null_sum_zero));
      end
    end
  end

  // hang detection: any transfer or register access restarts the count
  always @(posedge clk) begin
    if (rst || psel || (sample_ch.valid && sample_ch.ready) ||
        (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("tb_ofdm_null_subcarrier_snr_estimator_top NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    sample_ch.valid     = 1'b0;
    sample_ch.sample_re = '0;
    sample_ch.sample_im = '0;
    result_ch.ready     = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    rst     = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_format();
    test_short_vector_corners();
    test_random_vectors();
    test_result_backpressure();
    test_long_vector();

    // drain, then give the back end time to show any stray result
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (failures == 0 && expected_reports.size() == 0) begin
      $display("tb_ofdm_null_subcarrier_snr_estimator_top OK");
    end else begin
      $display("tb_ofdm_null_subcarrier_snr_estimator_top NOT OK");
    end
    $finish;
  end

endmodule

>>> ofdm_null_subcarrier_snr_estimator_top.f
rtl/onse_pkg.sv
rtl/onse_sample_if.sv
rtl/onse_result_if.sv
rtl/onse_fifo.sv
rtl/onse_front.sv
rtl/onse_div.sv
rtl/onse_back.sv
rtl/ofdm_null_subcarrier_snr_estimator_top.sv
sim/tb_ofdm_null_subcarrier_snr_estimator_top.sv
